// ----- hw/rtl/ltsc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ltsc_pkg
// Shared types and constants of the tagged-slot LRU cache directory.
// ----------------------------------------------------------------------------
package ltsc_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned COORD_W  = 64;
  localparam int unsigned LAYER_W  = 8;
  localparam int unsigned STAMP_W  = 64;

  localparam logic [CNT_W-1:0]   CAP_CNT   = CNT_W'(CAPACITY);
  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_REPORT = 1'b1;

  typedef struct packed {
    logic                      action;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [LAYER_W-1:0]        layer_id;
    logic [SLOT_W-1:0]         report_slot;
    logic                      load_ok;
  } in_t;

  typedef struct packed {
    logic              hit;
    logic              available;
    logic [SLOT_W-1:0] slot_index;
    logic              fill_request;
  } out_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [LAYER_W-1:0] layer;
  } tag_t;

  // Directory access issued by the sequencer.
  typedef struct packed {
    logic               rd_en;
    logic [IDX_W-1:0]   rd_idx;
    logic               tag_we;
    logic               stamp_we;
    logic               valid_set;
    logic [IDX_W-1:0]   wr_idx;
    tag_t               wr_tag;
    logic [STAMP_W-1:0] wr_stamp;
    logic               pres_we;
    logic [IDX_W-1:0]   pres_idx;
    logic               pres_val;
  } dir_ctl_t;

  // Registered read data of one directory entry.
  typedef struct packed {
    tag_t               tag;
    logic [STAMP_W-1:0] stamp;
    logic               valid;
    logic               present;
  } dir_rd_t;

  // Outcome of comparing one entry against the request and the best stamp.
  typedef struct packed {
    logic               match;
    logic               better;
    logic [STAMP_W-1:0] stamp;
  } cmp_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage : ltsc_pkg
`default_nettype wire

// ----- hw/rtl/ltsc_dir.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ltsc_dir
// Slot directory: tag and stamp memories with one registered read port and
// one write port, plus per-slot valid and present flags.
// ----------------------------------------------------------------------------
module ltsc_dir (
  input  logic               clk,
  input  logic               rst_n,
  input  ltsc_pkg::dir_ctl_t ctl,
  output ltsc_pkg::dir_rd_t  rd
);
  import ltsc_pkg::*;

  tag_t                tag_mem   [CAPACITY];
  logic [STAMP_W-1:0]  stamp_mem [CAPACITY];
  logic [CAPACITY-1:0] valid_r, valid_nxt;
  logic [CAPACITY-1:0] present_r, present_nxt;
  dir_rd_t             rd_r;

  always_ff @(posedge clk) begin
    if (ctl.tag_we) begin
      tag_mem[ctl.wr_idx] <= ctl.wr_tag;
    end
    if (ctl.stamp_we) begin
      stamp_mem[ctl.wr_idx] <= ctl.wr_stamp;
    end
    if (ctl.rd_en) begin
      rd_r.tag     <= tag_mem[ctl.rd_idx];
      rd_r.stamp   <= stamp_mem[ctl.rd_idx];
      rd_r.valid   <= valid_r[ctl.rd_idx];
      rd_r.present <= present_r[ctl.rd_idx];
    end
  end

  always_comb begin
    valid_nxt   = valid_r;
    present_nxt = present_r;
    if (ctl.valid_set) begin
      valid_nxt[ctl.wr_idx] = 1'b1;
    end
    if (ctl.pres_we) begin
      present_nxt[ctl.pres_idx] = ctl.pres_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      present_r <= '0;
    end else begin
      valid_r   <= valid_nxt;
      present_r <= present_nxt;
    end
  end

  assign rd = rd_r;

endmodule : ltsc_dir
`default_nettype wire

// ----- hw/rtl/ltsc_cmp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ltsc_cmp
// Shared compare unit: tests one directory entry for a tag match and for a
// stamp below the best seen so far in the current scan.
// ----------------------------------------------------------------------------
module ltsc_cmp (
  input  ltsc_pkg::tag_t               req_tag,
  input  ltsc_pkg::dir_rd_t            entry,
  input  logic [ltsc_pkg::STAMP_W-1:0] best,
  output ltsc_pkg::cmp_res_t           res
);
  import ltsc_pkg::*;

  logic [STAMP_W-1:0] eff_stamp;

  // A slot that was never filled has never been stamped either, so its
  // stamp counts as zero whatever the memory holds.
  assign eff_stamp  = entry.valid ? entry.stamp : '0;
  assign res.stamp  = eff_stamp;
  assign res.match  = entry.valid && (entry.tag == req_tag);
  assign res.better = (eff_stamp < best);

endmodule : ltsc_cmp
`default_nettype wire

// ----- hw/rtl/ltsc_seq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ltsc_seq
// Sequencer: accepts a word, scans the directory one slot per cycle through
// the shared compare unit, then updates the directory and posts the result.
// ----------------------------------------------------------------------------
module ltsc_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ltsc_pkg::in_t      in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output ltsc_pkg::out_t     out_word,
  output ltsc_pkg::dir_ctl_t ctl,
  input  ltsc_pkg::dir_rd_t  rd
);
  import ltsc_pkg::*;

  state_t             state_r, state_nxt;
  in_t                req_r, req_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic               hit_pres_r, hit_pres_nxt;
  logic [STAMP_W-1:0] best_r, best_nxt;
  logic [IDX_W-1:0]   victim_r, victim_nxt;
  logic [STAMP_W-1:0] use_clock_r, use_clock_nxt;
  out_t               res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               in_acc;
  logic               out_free;
  logic               scan_more;
  logic               rslot_ok;
  logic [IDX_W-1:0]   rslot_idx;
  logic [STAMP_W-1:0] next_clock;
  tag_t               req_tag;
  cmp_res_t           cmp;

  assign in_acc     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign scan_more  = (cnt_r < CAP_CNT);
  assign rslot_ok   = (32'(req_r.report_slot) < CAPACITY);
  assign rslot_idx  = IDX_W'(req_r.report_slot);
  assign next_clock = use_clock_r + 1'b1;
  assign req_tag    = '{x: req_r.coord_x, y: req_r.coord_y, z: req_r.coord_z,
                        layer: req_r.layer_id};

  ltsc_cmp u_cmp (
    .req_tag (req_tag),
    .entry   (rd),
    .best    (best_r),
    .res     (cmp)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_word.action == ACT_REPORT) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!scan_more && !cmp_vld_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the state machine: handshake and directory access.
  always_comb begin
    in_stall = 1'b1;
    ctl      = '0;
    ctl.rd_idx = cnt_r[IDX_W-1:0];
    ctl.wr_tag = req_tag;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_SCAN: begin
        ctl.rd_en = scan_more;
      end
      ST_FINISH: begin
        if (out_free) begin
          if (req_r.action == ACT_REPORT) begin
            ctl.pres_we  = rslot_ok;
            ctl.pres_idx = rslot_idx;
            ctl.pres_val = req_r.load_ok;
          end else if (found_r) begin
            ctl.stamp_we = 1'b1;
            ctl.wr_idx   = hit_idx_r;
            ctl.wr_stamp = next_clock;
          end else begin
            ctl.tag_we    = 1'b1;
            ctl.stamp_we  = 1'b1;
            ctl.valid_set = 1'b1;
            ctl.wr_idx    = victim_r;
            ctl.wr_stamp  = next_clock;
            ctl.pres_we   = 1'b1;
            ctl.pres_idx  = victim_r;
            ctl.pres_val  = 1'b0;
          end
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    req_nxt       = req_r;
    cnt_nxt       = cnt_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    found_nxt     = found_r;
    hit_idx_nxt   = hit_idx_r;
    hit_pres_nxt  = hit_pres_r;
    best_nxt      = best_r;
    victim_nxt    = victim_r;
    use_clock_nxt = use_clock_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (in_acc) begin
      req_nxt    = in_word;
      cnt_nxt    = '0;
      found_nxt  = 1'b0;
      best_nxt   = STAMP_MAX;
      victim_nxt = '0;
    end

    if (state_r == ST_SCAN) begin
      if (scan_more) begin
        cnt_nxt     = cnt_r + 1'b1;
        cmp_vld_nxt = 1'b1;
        cmp_idx_nxt = cnt_r[IDX_W-1:0];
      end
      if (cmp_vld_r) begin
        // The first matching slot wins; later matches are ignored.
        if (cmp.match && !found_r) begin
          found_nxt    = 1'b1;
          hit_idx_nxt  = cmp_idx_r;
          hit_pres_nxt = rd.present;
        end
        // Strictly smaller only, so the lowest slot keeps a tie.
        if (cmp.better) begin
          best_nxt   = cmp.stamp;
          victim_nxt = cmp_idx_r;
        end
      end
    end

    if (state_r == ST_FINISH && out_free) begin
      out_valid_nxt = 1'b1;
      if (req_r.action == ACT_REPORT) begin
        res_nxt.hit          = 1'b0;
        res_nxt.available    = rslot_ok && req_r.load_ok;
        res_nxt.slot_index   = req_r.report_slot;
        res_nxt.fill_request = 1'b0;
      end else if (found_r) begin
        use_clock_nxt        = next_clock;
        res_nxt.hit          = 1'b1;
        res_nxt.available    = hit_pres_r;
        res_nxt.slot_index   = SLOT_W'(hit_idx_r);
        res_nxt.fill_request = 1'b0;
      end else begin
        use_clock_nxt        = next_clock;
        res_nxt.hit          = 1'b0;
        res_nxt.available    = 1'b0;
        res_nxt.slot_index   = SLOT_W'(victim_r);
        res_nxt.fill_request = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cmp_vld_r   <= 1'b0;
      use_clock_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      use_clock_r <= use_clock_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    cnt_r      <= cnt_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    found_r    <= found_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_pres_r <= hit_pres_nxt;
    best_r     <= best_nxt;
    victim_r   <= victim_nxt;
    res_r      <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = res_r;

endmodule : ltsc_seq
`default_nettype wire

// ----- hw/rtl/lru_tagged_slot_cache_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lru_tagged_slot_cache_core
// Fully associative LRU cache directory with timestamped slots.
// ----------------------------------------------------------------------------
// A lookup word is scanned against the directory one slot per cycle through a
// single read port and one shared compare unit, and the block accepts no new
// word until the scan is done; its result is written into the output register
// as the block returns to idle. A load report needs no scan. The finished
// result waits in the output register, and the next word may be accepted while
// it is still stalled. Slot valid and present flags are cleared by reset, so no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_tagged_slot_cache_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  ltsc_pkg::in_t  in_word,
  output logic           out_valid,
  input  logic           out_stall,
  output ltsc_pkg::out_t out_word
);
  import ltsc_pkg::*;

  dir_ctl_t dir_ctl;
  dir_rd_t  dir_rd;

  ltsc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .ctl       (dir_ctl),
    .rd        (dir_rd)
  );

  ltsc_dir u_dir (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (dir_ctl),
    .rd    (dir_rd)
  );

endmodule : lru_tagged_slot_cache_core
`default_nettype wire

// ----- hw/rtl/ltsc_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ltsc_checker
// Port-level checks of the cache directory, bound to the top level.
// ----------------------------------------------------------------------------
module ltsc_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input ltsc_pkg::in_t  in_word,
  input logic           out_valid,
  input logic           out_stall,
  input ltsc_pkg::out_t out_word
);
  import ltsc_pkg::*;

  // A held result word must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // Hit and fill request exclude each other.
  a_hit_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_word.hit && out_word.fill_request))
    else $error("hit and fill request together");

  // A freshly allocated slot never holds a present chunk.
  a_fill_avail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.fill_request |-> !out_word.available)
    else $error("fill request with available set");

  // One word at a time: the block is busy straight after an acceptance.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while busy");

  // A report taken while the result register is empty is posted straight from
  // the finish state, echoes the reported slot and never flags a hit.
  a_report: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_word.action == ACT_REPORT && !out_valid |=> ##1
      out_valid && !out_word.hit && !out_word.fill_request &&
      out_word.slot_index == $past(in_word.report_slot, 2))
    else $error("report result mismatch");

endmodule : ltsc_checker

bind lru_tagged_slot_cache_core ltsc_checker u_ltsc_checker (.*);
`default_nettype wire

// ----- verif/lru_tagged_slot_cache_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_tagged_slot_cache_core_test
// Self-checking bench for the tagged-slot LRU cache directory. A short table
// of lookups and load reports walks through the reset state, the coordinate
// extremes, hits on slots whose fill failed and reports for empty slots. It
// is followed by random traffic drawn from a small pool of recurring tags, so
// that hits, evictions and near misses all occur. Every reply is checked
// against a behavioural copy of the directory, with random gaps on both sides.
// ----------------------------------------------------------------------------
module lru_tagged_slot_cache_core_test;
  import ltsc_pkg::*;

  localparam int RANDOM_WORDS = 1150;
  localparam int POOL_SIZE    = 22;
  localparam int IDLE_PCT     = 31;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic [63:0] C_ZERO = 64'h0000_0000_0000_0000;
  localparam logic [63:0] C_ONE  = 64'h0000_0000_0000_0001;
  localparam logic [63:0] C_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] C_MIN  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] C_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    in_t  word;
    bit   typed;
    out_t want;
  } cache_row_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_word   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_word;

  always #5 clk = ~clk;

  lru_tagged_slot_cache_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  cache_row_t stim_rows[$];
  cache_row_t flight_rows[$];
  out_t       predicted_replies[$];
  tag_t       tag_pool[POOL_SIZE];

  // Behavioural copy of the directory.
  logic [63:0] dir_x[CAPACITY];
  logic [63:0] dir_y[CAPACITY];
  logic [63:0] dir_z[CAPACITY];
  logic [7:0]  dir_layer[CAPACITY];
  bit          dir_valid[CAPACITY];
  bit          dir_present[CAPACITY];
  logic [63:0] dir_stamp[CAPACITY];
  logic [63:0] use_clock;

  int         words_sent  = 0;
  int         words_taken = 0;
  int         words_total = 0;
  int         cycles      = 0;
  int         errors      = 0;
  bit         taken_flag  = 1'b0;
  bit         calm        = 1'b0;
  cache_row_t next_row;
  cache_row_t taken_row;
  out_t       got_reply;
  out_t       want_reply;

  function automatic void clear_directory();
    int i;
    for (i = 0; i < CAPACITY; i++) begin
      dir_x[i]       = '0;
      dir_y[i]       = '0;
      dir_z[i]       = '0;
      dir_layer[i]   = '0;
      dir_valid[i]   = 1'b0;
      dir_present[i] = 1'b0;
      dir_stamp[i]   = '0;
    end
    use_clock = '0;
  endfunction

  function automatic out_t directory_step(in_t w);
    out_t        r;
    int          i;
    int          hit_idx;
    int          victim;
    logic [63:0] best;
    r = '0;
    if (w.action == ACT_REPORT) begin
      r.slot_index = w.report_slot;
      if (int'(w.report_slot) < int'(CAPACITY)) begin
        dir_present[w.report_slot] = w.load_ok;
        r.available = w.load_ok;
      end
      return r;
    end
    hit_idx = -1;
    for (i = 0; i < CAPACITY; i++) begin
      if (hit_idx < 0 && dir_valid[i] && dir_x[i] == w.coord_x && dir_y[i] == w.coord_y &&
          dir_z[i] == w.coord_z && dir_layer[i] == w.layer_id) begin
        hit_idx = i;
      end
    end
    use_clock = use_clock + 64'd1;
    if (hit_idx >= 0) begin
      dir_stamp[hit_idx] = use_clock;
      r.hit          = 1'b1;
      r.available    = dir_present[hit_idx];
      r.slot_index   = hit_idx[SLOT_W-1:0];
      return r;
    end
    // The victim is the first slot holding the oldest stamp below the maximum.
    victim = 0;
    best   = STAMP_MAX;
    for (i = 0; i < CAPACITY; i++) begin
      if (dir_stamp[i] < best) begin
        best   = dir_stamp[i];
        victim = i;
      end
    end
    dir_x[victim]       = w.coord_x;
    dir_y[victim]       = w.coord_y;
    dir_z[victim]       = w.coord_z;
    dir_layer[victim]   = w.layer_id;
    dir_valid[victim]   = 1'b1;
    dir_present[victim] = 1'b0;
    dir_stamp[victim]   = use_clock;
    r.slot_index   = victim[SLOT_W-1:0];
    r.fill_request = 1'b1;
    return r;
  endfunction

  // Lookup word; the report fields are ignored by a lookup and carry noise.
  function automatic in_t lookup_word(logic [63:0] x, logic [63:0] y, logic [63:0] z,
                                      logic [7:0] layer);
    in_t w;
    w.action      = ACT_LOOKUP;
    w.coord_x     = x;
    w.coord_y     = y;
    w.coord_z     = z;
    w.layer_id    = layer;
    w.report_slot = SLOT_W'($urandom);
    w.load_ok     = 1'($urandom);
    return w;
  endfunction

  // Report word; the tag fields are ignored by a report and carry noise.
  function automatic in_t report_word(logic [SLOT_W-1:0] slot, logic ok);
    in_t w;
    w.action      = ACT_REPORT;
    w.coord_x     = {$urandom, $urandom};
    w.coord_y     = {$urandom, $urandom};
    w.coord_z     = {$urandom, $urandom};
    w.layer_id    = 8'($urandom);
    w.report_slot = slot;
    w.load_ok     = ok;
    return w;
  endfunction

  function automatic out_t reply(logic hit, logic avail, logic [SLOT_W-1:0] slot, logic fill);
    out_t r;
    r.hit          = hit;
    r.available    = avail;
    r.slot_index   = slot;
    r.fill_request = fill;
    return r;
  endfunction

  function automatic void add_row(in_t w, bit typed, out_t want);
    cache_row_t row;
    row.word  = w;
    row.typed = typed;
    row.want  = want;
    stim_rows.push_back(row);
  endfunction

  function automatic logic [63:0] pick_coord();
    case ($urandom_range(9))
      0:       return C_ZERO;
      1:       return C_MAX;
      2:       return C_MIN;
      3:       return C_ONES;
      4:       return 64'($urandom_range(7));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic tag_t fresh_tag();
    tag_t t;
    t.x     = pick_coord();
    t.y     = pick_coord();
    t.z     = pick_coord();
    t.layer = ($urandom_range(3) == 0) ? 8'($urandom_range(3)) : 8'($urandom);
    return t;
  endfunction

  function automatic void build_random_rows();
    int          n;
    int          roll;
    int          bit_no;
    tag_t        t;
    logic [63:0] flip;
    for (n = 0; n < POOL_SIZE; n++) tag_pool[n] = fresh_tag();
    for (n = 0; n < RANDOM_WORDS; n++) begin
      roll = $urandom_range(99);
      if (roll < 22) begin
        add_row(report_word(SLOT_W'($urandom_range(15)), 1'($urandom)), 1'b0, '0);
      end else if (roll < 65) begin
        t = tag_pool[$urandom_range(POOL_SIZE - 1)];
        add_row(lookup_word(t.x, t.y, t.z, t.layer), 1'b0, '0);
      end else if (roll < 75) begin
        // A near miss: one bit of one tag field differs from a recurring tag.
        t      = tag_pool[$urandom_range(POOL_SIZE - 1)];
        bit_no = $urandom_range(63);
        flip   = C_ONE << bit_no;
        case ($urandom_range(3))
          0:       t.x = t.x ^ flip;
          1:       t.y = t.y ^ flip;
          2:       t.z = t.z ^ flip;
          default: t.layer = t.layer ^ 8'(1 << (bit_no % 8));
        endcase
        add_row(lookup_word(t.x, t.y, t.z, t.layer), 1'b0, '0);
      end else begin
        t = fresh_tag();
        tag_pool[$urandom_range(POOL_SIZE - 1)] = t;
        add_row(lookup_word(t.x, t.y, t.z, t.layer), 1'b0, '0);
      end
    end
  endfunction

  // Stimulus and the receiver's stall change on the falling edge.
  always @(negedge clk) begin
    if (rst_n) begin
      calm = (words_sent >= 400) && (words_sent < 650);
      if (in_valid && !taken_flag) begin
        // The offered word has not been taken yet and stays as it is.
      end else if (stim_rows.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        next_row = stim_rows.pop_front();
        flight_rows.push_back(next_row);
        in_word  <= next_row.word;
        in_valid <= 1'b1;
        words_sent++;
      end else begin
        in_valid <= 1'b0;
      end
      taken_flag = 1'b0;
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      cycles++;
      if (in_valid && !in_stall) begin
        taken_row = flight_rows.pop_front();
        got_reply = directory_step(in_word);
        predicted_replies.push_back(taken_row.typed ? taken_row.want : got_reply);
        taken_flag = 1'b1;
        words_taken++;
      end
      if (out_valid && !out_stall) begin
        if (predicted_replies.size() == 0) begin
          errors++;
          $display("%0t: unexpected reply, expected none, actual %0b %0b %0d %0b",
                   $time, out_word.hit, out_word.available, out_word.slot_index,
                   out_word.fill_request);
        end else begin
          want_reply = predicted_replies.pop_front();
          if (out_word.hit !== want_reply.hit || out_word.available !== want_reply.available ||
              out_word.slot_index !== want_reply.slot_index ||
              out_word.fill_request !== want_reply.fill_request) begin
            errors++;
            $display("%0t: mismatch, expected %0b %0b %0d %0b, actual %0b %0b %0d %0b",
                     $time, want_reply.hit, want_reply.available, want_reply.slot_index,
                     want_reply.fill_request, out_word.hit, out_word.available,
                     out_word.slot_index, out_word.fill_request);
          end
        end
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    clear_directory();

    // After reset no slot may match, not even the all-zero tag.
    add_row(lookup_word(C_ZERO, C_ZERO, C_ZERO, 8'd0), 1'b1, reply(1'b0, 1'b0, 4'd0, 1'b1));
    add_row(lookup_word(C_ZERO, C_ZERO, C_ZERO, 8'd0), 1'b1, reply(1'b1, 1'b0, 4'd0, 1'b0));
    add_row(report_word(4'd0, 1'b1), 1'b1, reply(1'b0, 1'b1, 4'd0, 1'b0));
    add_row(lookup_word(C_ZERO, C_ZERO, C_ZERO, 8'd0), 1'b1, reply(1'b1, 1'b1, 4'd0, 1'b0));
    add_row(lookup_word(C_MIN, C_MIN, C_MIN, 8'd255), 1'b1, reply(1'b0, 1'b0, 4'd1, 1'b1));
    add_row(lookup_word(C_MAX, C_MAX, C_MAX, 8'd0), 1'b1, reply(1'b0, 1'b0, 4'd2, 1'b1));
    // A failed fill leaves the slot matchable but not present.
    add_row(report_word(4'd2, 1'b0), 1'b1, reply(1'b0, 1'b0, 4'd2, 1'b0));
    add_row(lookup_word(C_MAX, C_MAX, C_MAX, 8'd0), 1'b1, reply(1'b1, 1'b0, 4'd2, 1'b0));
    // A report for a slot that holds no tag yet.
    add_row(report_word(4'd15, 1'b1), 1'b1, reply(1'b0, 1'b1, 4'd15, 1'b0));
    add_row(lookup_word(C_ONES, C_ONES, C_ONES, 8'd255), 1'b0, '0);
    add_row(lookup_word(C_ZERO, C_ZERO, C_ZERO, 8'd1), 1'b0, '0);
    add_row(lookup_word(C_ONE, C_ZERO, C_ZERO, 8'd0), 1'b0, '0);
    add_row(lookup_word(C_ZERO, C_ONE, C_ZERO, 8'd0), 1'b0, '0);
    add_row(lookup_word(C_ZERO, C_ZERO, C_ONE, 8'd0), 1'b0, '0);
    add_row(report_word(4'd1, 1'b1), 1'b0, '0);
    add_row(report_word(4'd1, 1'b0), 1'b0, '0);
    add_row(lookup_word(C_MIN, C_MIN, C_MIN, 8'd255), 1'b0, '0);
    add_row(lookup_word(C_MAX, C_MIN, C_ZERO, 8'd170), 1'b0, '0);
    add_row(lookup_word(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                        64'h0123_4567_89AB_CDEF, 8'd85), 1'b0, '0);
    add_row(report_word(4'd15, 1'b0), 1'b0, '0);
    add_row(lookup_word(C_ZERO, C_ZERO, C_ZERO, 8'd0), 1'b0, '0);

    build_random_rows();
    words_total = stim_rows.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (words_taken < words_total) @(posedge clk);
    while (predicted_replies.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && predicted_replies.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
